// ===== rtl/accumulator_cpu_core_defines.svh =====
// ----------------------------------------------------------------------------
// accumulator cpu core assertion macros
// small wrappers so that assertions vanish in synthesis builds
// ----------------------------------------------------------------------------
`ifndef ACCUMULATOR_CPU_CORE_DEFINES_SVH
`define ACCUMULATOR_CPU_CORE_DEFINES_SVH
`ifndef SYNTH
// property must hold on every edge out of reset
`define ACC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ACC_ASSERT(label, clk, rst_n, prop, msg)
`define ACC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/acc_pkg.sv =====
// ----------------------------------------------------------------------------
// acc_pkg
// shared types and constants of the accumulator cpu core
// ----------------------------------------------------------------------------
`default_nettype none
package acc_pkg;
	localparam int MemWords = 128;
	localparam int DataBits = 32;
	localparam int AddrBits = $clog2(MemWords);
	localparam int OpcBits  = 8;
	localparam int CntBits  = $clog2(DataBits + 1);

	localparam logic [1:0] OP_LOAD    = 2'd0;
	localparam logic [1:0] OP_STEP    = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;

	localparam logic [OpcBits-1:0] I_LOAD  = 8'd0;
	localparam logic [OpcBits-1:0] I_STORE = 8'd1;
	localparam logic [OpcBits-1:0] I_ADD   = 8'd2;
	localparam logic [OpcBits-1:0] I_MUL   = 8'd3;
	localparam logic [OpcBits-1:0] I_DIV   = 8'd4;
	localparam logic [OpcBits-1:0] I_SUB   = 8'd5;
	localparam logic [OpcBits-1:0] I_JMP   = 8'd6;
	localparam logic [OpcBits-1:0] I_BZ    = 8'd7;
	localparam logic [OpcBits-1:0] I_BP    = 8'd8;
	localparam logic [OpcBits-1:0] I_BN    = 8'd9;
	localparam logic [OpcBits-1:0] I_PRINT = 8'd10;
	localparam logic [OpcBits-1:0] I_READ  = 8'd11;
	localparam logic [OpcBits-1:0] I_STOP  = 8'd12;

	typedef struct packed {
		logic [1:0]                 operation;
		logic [6:0]                 load_address;
		logic [7:0]                 load_opcode;
		logic signed [31:0]         load_operand;
		logic signed [31:0]         keyboard_value;
	} in_word_t;

	typedef struct packed {
		logic [6:0]         program_counter;
		logic signed [31:0] accumulator;
		logic [7:0]         executed_opcode;
		logic               print_valid;
		logic [6:0]         print_address;
		logic signed [31:0] print_value;
		logic               input_consumed;
		logic               halted;
		logic               invalid_opcode;
		logic               divide_by_zero;
	} out_word_t;

	typedef struct packed {
		logic                start;
		logic [DataBits-1:0] dividend;
		logic [DataBits-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DataBits-1:0] quotient;
	} div_rsp_t;
endpackage
`default_nettype wire

// ===== rtl/acc_ram.sv =====
// ----------------------------------------------------------------------------
// acc_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module acc_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== rtl/acc_div.sv =====
// ----------------------------------------------------------------------------
// acc_div
// signed truncating divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module acc_div import acc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);
	logic [DataBits-1:0] rem_q, quo_q, dvs_q;
	logic [CntBits-1:0]  cnt_q;
	logic                busy_q, neg_q, done_q;
	logic [DataBits:0]   trial;
	logic [DataBits-1:0] shifted;
	logic [DataBits-1:0] a_mag, b_mag;

	assign a_mag   = req.dividend[DataBits-1] ? DataBits'(-req.dividend) : req.dividend;
	assign b_mag   = req.divisor[DataBits-1]  ? DataBits'(-req.divisor)  : req.divisor;
	assign shifted = {rem_q[DataBits-2:0], quo_q[DataBits-1]};
	assign trial   = {1'b0, shifted} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntBits'(DataBits);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntBits'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring shift-subtract on magnitudes
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= a_mag;
			dvs_q <= b_mag;
			neg_q <= req.dividend[DataBits-1] ^ req.divisor[DataBits-1];
		end else if (busy_q) begin
			if (!trial[DataBits]) begin
				rem_q <= trial[DataBits-1:0];
				quo_q <= {quo_q[DataBits-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[DataBits-2:0], 1'b0};
			end
		end
	end

	assign rsp = {done_q, (neg_q ? DataBits'(-quo_q) : quo_q)};
endmodule
`default_nettype wire

// ===== rtl/accumulator_cpu_core.sv =====
// ----------------------------------------------------------------------------
// accumulator_cpu_core
// accumulator machine over a 128 word program and data memory
// ----------------------------------------------------------------------------
// channel   | direction | handshake        | content
// in        | input     | in_valid/stall   | in_word_t: op, load fields, keyboard
// out       | output    | out_valid/stall  | out_word_t: pc, acc, flags, print
// cfg       | input     | cfg_valid/ready  | start address
//
// load and restart: result word in the cycle after acceptance; one word a
// cycle while the output is not stalled
// a step: fetch, operand read, execute; result word registered at the end of
// execute; a divide adds the run of the bit-serial divider
// one item at a time; the next is taken once the result register is empty
// or being drained
// reset clears pc, acc, halt and start address; memory contents undefined
// ----------------------------------------------------------------------------
`default_nettype none
`include "accumulator_cpu_core_defines.svh"
module accumulator_cpu_core import acc_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire in_word_t in_data,
	output logic          out_valid,
	input  wire logic     out_stall,
	output out_word_t     out_data,
	input  wire logic     cfg_valid,
	output logic          cfg_ready,
	input  wire logic [6:0] cfg_data
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_FETCH = 3'd1;
	localparam logic [2:0] S_OPND  = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;

	logic [2:0]          state_q;
	logic [AddrBits-1:0] pc_q, start_q;
	logic [DataBits-1:0] acc_q, kbd_q;
	logic                halt_q;
	logic [OpcBits-1:0]  opc_q;
	logic [AddrBits-1:0] ea_q;

	// memory ports
	logic                opc_we, opd_we;
	logic [AddrBits-1:0] opc_waddr, opd_waddr, opc_raddr, opd_raddr;
	logic [OpcBits-1:0]  opc_wdata, opc_rdata;
	logic [DataBits-1:0] opd_wdata, opd_rdata;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic      accept, out_free, fin, ctl_done;
	out_word_t res, ctl_res;

	// result register frees as it drains
	assign out_free  = !out_valid || !out_stall;
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// load, restart and unused operation answer straight from idle
	assign ctl_done  = accept && in_data.operation != OP_STEP;

	acc_ram #(.Width(OpcBits), .Depth(MemWords)) u_opc_ram (
		.clk(clk), .we(opc_we), .waddr(opc_waddr), .wdata(opc_wdata),
		.raddr(opc_raddr), .rdata(opc_rdata));
	acc_ram #(.Width(DataBits), .Depth(MemWords)) u_opd_ram (
		.clk(clk), .we(opd_we), .waddr(opd_waddr), .wdata(opd_wdata),
		.raddr(opd_raddr), .rdata(opd_rdata));
	acc_div u_div (.clk(clk), .arst_n(arst_n), .req(div_req), .rsp(div_rsp));

	// ram read addresses: pc while idle, operand-derived address afterwards
	// (held through execute and divide so the operand value stays put)
	assign opc_raddr = pc_q;
	assign opd_raddr = (state_q == S_FETCH) ? opd_rdata[AddrBits-1:0]
		: (state_q == S_IDLE) ? pc_q : ea_q;

	always_comb begin
		opc_we    = accept && in_data.operation == OP_LOAD;
		opc_waddr = in_data.load_address;
		opc_wdata = in_data.load_opcode;
		opd_we    = opc_we;
		opd_waddr = in_data.load_address;
		opd_wdata = in_data.load_operand;
		if (state_q == S_EXEC && !halt_q && opc_q == I_STORE) begin
			opd_we = 1'b1; opd_waddr = ea_q; opd_wdata = acc_q;
		end else if (state_q == S_EXEC && !halt_q && opc_q == I_READ) begin
			opd_we = 1'b1; opd_waddr = ea_q; opd_wdata = kbd_q;
		end
	end

	assign div_req = '{
		start:    (state_q == S_EXEC && !halt_q && opc_q == I_DIV && opd_rdata != '0),
		dividend: acc_q,
		divisor:  opd_rdata
	};

	// execute stage: operand value mv is on opd_rdata
	always_comb begin
		logic [DataBits-1:0] mv, prod;
		logic [AddrBits-1:0] nxt;
		mv   = opd_rdata;
		prod = acc_q * mv;
		nxt  = pc_q + 1'b1;
		res  = '0;
		res.accumulator     = acc_q;
		res.executed_opcode = opc_q;
		res.halted          = halt_q;
		if (halt_q) begin
			nxt = pc_q;
		end else begin
			unique case (opc_q)
				I_LOAD:  res.accumulator = mv;
				I_STORE: ;
				I_ADD:   res.accumulator = acc_q + mv;
				I_MUL:   res.accumulator = prod;
				I_DIV:   res.divide_by_zero = mv == '0;
				I_SUB:   res.accumulator = acc_q - mv;
				I_JMP:   nxt = ea_q;
				I_BZ:    if (acc_q == '0) nxt = ea_q;
				I_BP:    if (acc_q != '0 && !acc_q[DataBits-1]) nxt = ea_q;
				I_BN:    if (acc_q[DataBits-1]) nxt = ea_q;
				I_PRINT: begin
					res.print_valid   = 1'b1;
					res.print_address = ea_q;
					res.print_value   = mv;
				end
				I_READ:  res.input_consumed = 1'b1;
				I_STOP:  begin
					nxt = pc_q;
					res.halted = 1'b1;
				end
				default: res.invalid_opcode = 1'b1;
			endcase
		end
		// quotient comes back from the divider
		if (state_q == S_DIV) begin
			res.accumulator = div_rsp.quotient;
		end
		res.program_counter = nxt;
	end

	// result word for the items that need no execute
	always_comb begin
		ctl_res = '0;
		ctl_res.program_counter = pc_q;
		ctl_res.accumulator     = acc_q;
		ctl_res.halted          = halt_q;
		if (in_data.operation == OP_RESTART) begin
			ctl_res.program_counter = start_q;
			ctl_res.accumulator     = '0;
			ctl_res.halted          = 1'b0;
		end
	end

	assign fin = (state_q == S_EXEC && !div_req.start) || (state_q == S_DIV && div_rsp.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pc_q      <= '0;
			acc_q     <= '0;
			halt_q    <= 1'b0;
			start_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				start_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && in_data.operation == OP_STEP) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_OPND;
				S_OPND:  state_q <= S_EXEC;
				S_EXEC:  state_q <= div_req.start ? S_DIV : S_IDLE;
				S_DIV:   if (div_rsp.done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (fin || ctl_done) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
			if (fin) begin
				out_data <= res;
				pc_q     <= res.program_counter;
				halt_q   <= res.halted;
				acc_q    <= res.accumulator;
			end else if (ctl_done) begin
				out_data <= ctl_res;
				pc_q     <= ctl_res.program_counter;
				halt_q   <= ctl_res.halted;
				acc_q    <= ctl_res.accumulator;
			end
		end
	end

	// capture the keyboard value on acceptance and fetch results for the execute stage
	always_ff @(posedge clk) begin
		if (accept) begin
			kbd_q <= in_data.keyboard_value;
		end
		if (state_q == S_FETCH) begin
			opc_q <= opc_rdata;
			ea_q  <= opd_rdata[AddrBits-1:0];
		end
	end

	`ACC_ASSERT(a_no_accept_busy, clk, arst_n,
		!(accept && state_q != S_IDLE), "accept while busy")
	`ACC_ASSERT_NEXT(a_step_fetch, clk, arst_n,
		accept && in_data.operation == OP_STEP, state_q == S_FETCH, "step did not fetch")
	`ACC_ASSERT_NEXT(a_fin_valid, clk, arst_n, fin, out_valid, "result lost")
endmodule
`default_nettype wire
